// ===== sv/dhcp_rop_pkg.sv =====
package dhcp_rop_pkg;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_OPT   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // header opcode of a reply
    localparam logic [7:0] OP_REPLY = 8'd2;

    // option codes
    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_NTP    = 8'd42;
    localparam logic [7:0] OPT_LEASE  = 8'd51;
    localparam logic [7:0] OPT_MTYPE  = 8'd53;
    localparam logic [7:0] OPT_SRV_ID = 8'd54;
    localparam logic [7:0] OPT_END    = 8'd255;

    // message types
    localparam logic [7:0] MT_OFFER = 8'd2;
    localparam logic [7:0] MT_ACK   = 8'd5;
    localparam logic [7:0] MT_NAK   = 8'd6;

    // result events
    localparam logic [1:0] EV_REQUEST  = 2'd0;
    localparam logic [1:0] EV_ASSIGNED = 2'd1;
    localparam logic [1:0] EV_REFUSED  = 2'd2;
    localparam logic [1:0] EV_IGNORED  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  opcode;
        logic [31:0] offered_ip;
        logic [31:0] server_ip;
        logic [7:0]  opt_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] client_ip;
        logic [31:0] server_addr;
        logic [31:0] net_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_addr;
        logic [31:0] ntp_addr;
        logic [31:0] server_ident;
        logic [31:0] lease_seconds;
    } out_item_t;

endpackage

// ===== sv/dhcp_reply_option_parser.sv =====
// DHCP reply option parser. Takes one item per cycle: a start transfer with the
// header opcode and addresses, then the options area one byte per transfer, and
// emits one result on the end option of a reply (opcode 2), classifying it as
// request needed (first offer), address assigned (first ack), refused (first
// nak) or ignored, together with the header addresses and the first four bytes
// of the mask, router, DNS, NTP, server-id and lease options (zero if absent).
// Every item is parsed in the cycle it is transferred, so the block sustains
// one item per clock; the only thing that holds input back is a result sitting
// in the output register while the consumer stalls. The result register is
// loaded as the end byte is taken. A clear transfer resets the session flags.
module dhcp_reply_option_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  dhcp_rop_pkg::in_item_t item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output dhcp_rop_pkg::out_item_t res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CODE,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic        is_reply_reg, is_reply_next;
    logic [7:0]  code_reg,     code_next;
    logic [7:0]  left_reg,     left_next;
    logic [2:0]  idx_reg,      idx_next;
    logic [31:0] shift_reg,    shift_next;
    logic [7:0]  mtype_reg,    mtype_next;
    logic [31:0] lease_reg,    lease_next;
    logic [31:0] mask_reg,     mask_next;
    logic [31:0] router_reg,   router_next;
    logic [31:0] dns_reg,      dns_next;
    logic [31:0] ntp_reg,      ntp_next;
    logic [31:0] ident_reg,    ident_next;
    logic [31:0] yaddr_reg,    yaddr_next;
    logic [31:0] saddr_reg,    saddr_next;
    logic        offer_seen_reg,  offer_seen_next;
    logic        answer_seen_reg, answer_seen_next;
    logic        res_valid_reg, res_valid_next;
    dhcp_rop_pkg::out_item_t res_reg, res_next;

    logic        accept;
    logic        commit;
    logic [31:0] commit_val;
    logic [31:0] byte_placed;
    logic [7:0]  left_dec;
    logic [1:0]  ev;

    // Input waits only while a result is held by a stalled consumer.
    assign item_stall = res_valid_reg && res_stall;
    assign accept     = item_valid && !item_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign byte_placed = {item.opt_byte, 24'd0} >> {idx_reg[1:0], 3'b000};
    assign left_dec    = left_reg - 8'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        is_reply_next    = is_reply_reg;
        code_next        = code_reg;
        left_next        = left_reg;
        idx_next         = idx_reg;
        shift_next       = shift_reg;
        mtype_next       = mtype_reg;
        lease_next       = lease_reg;
        mask_next        = mask_reg;
        router_next      = router_reg;
        dns_next         = dns_reg;
        ntp_next         = ntp_reg;
        ident_next       = ident_reg;
        yaddr_next       = yaddr_reg;
        saddr_next       = saddr_reg;
        offer_seen_next  = offer_seen_reg;
        answer_seen_next = answer_seen_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && res_stall;
        commit           = 1'b0;
        commit_val       = 32'd0;
        ev               = dhcp_rop_pkg::EV_IGNORED;

        if (accept)
        begin
            case (item.kind)
                dhcp_rop_pkg::KIND_START:
                begin
                    is_reply_next = (item.opcode == dhcp_rop_pkg::OP_REPLY);
                    yaddr_next    = item.offered_ip;
                    saddr_next    = item.server_ip;
                    code_next     = 8'd0;
                    left_next     = 8'd0;
                    idx_next      = 3'd0;
                    shift_next    = 32'd0;
                    mtype_next    = 8'd0;
                    lease_next    = 32'd0;
                    mask_next     = 32'd0;
                    router_next   = 32'd0;
                    dns_next      = 32'd0;
                    ntp_next      = 32'd0;
                    ident_next    = 32'd0;
                    phase_next    = (item.opcode == dhcp_rop_pkg::OP_REPLY) ? PH_CODE
                                                                            : PH_IDLE;
                end
                dhcp_rop_pkg::KIND_CLEAR:
                begin
                    offer_seen_next  = 1'b0;
                    answer_seen_next = 1'b0;
                end
                dhcp_rop_pkg::KIND_OPT:
                begin
                    case (phase_reg)
                        PH_CODE:
                        begin
                            if (item.opt_byte == dhcp_rop_pkg::OPT_END)
                            begin
                                phase_next = PH_IDLE;
                                if (is_reply_reg)
                                begin
                                    // classify against the session flags
                                    if (mtype_reg == dhcp_rop_pkg::MT_OFFER)
                                    begin
                                        if (!offer_seen_reg)
                                        begin
                                            ev              = dhcp_rop_pkg::EV_REQUEST;
                                            offer_seen_next = 1'b1;
                                        end
                                    end
                                    else if (mtype_reg == dhcp_rop_pkg::MT_ACK ||
                                             mtype_reg == dhcp_rop_pkg::MT_NAK)
                                    begin
                                        if (!answer_seen_reg)
                                        begin
                                            answer_seen_next = 1'b1;
                                            ev = (mtype_reg == dhcp_rop_pkg::MT_ACK)
                                               ? dhcp_rop_pkg::EV_ASSIGNED
                                               : dhcp_rop_pkg::EV_REFUSED;
                                        end
                                    end
                                    res_valid_next         = 1'b1;
                                    res_next.event_res     = ev;
                                    res_next.client_ip     = yaddr_reg;
                                    res_next.server_addr   = saddr_reg;
                                    res_next.net_mask      = mask_reg;
                                    res_next.router_addr   = router_reg;
                                    res_next.dns_addr      = dns_reg;
                                    res_next.ntp_addr      = ntp_reg;
                                    res_next.server_ident  = ident_reg;
                                    res_next.lease_seconds = lease_reg;
                                end
                            end
                            else if (item.opt_byte != dhcp_rop_pkg::OPT_PAD)
                            begin
                                code_next  = item.opt_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            left_next  = item.opt_byte;
                            idx_next   = 3'd0;
                            shift_next = 32'd0;
                            if (item.opt_byte == 8'd0)
                            begin
                                commit     = 1'b1;
                                commit_val = 32'd0;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            // only the first four data bytes are kept
                            if (!idx_reg[2])
                            begin
                                shift_next = shift_reg | byte_placed;
                                idx_next   = idx_reg + 3'd1;
                            end
                            left_next = left_dec;
                            if (left_dec == 8'd0)
                            begin
                                commit     = 1'b1;
                                commit_val = shift_next;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (commit)
        begin
            phase_next = PH_CODE;
            case (code_reg)
                dhcp_rop_pkg::OPT_MTYPE:  mtype_next  = commit_val[31:24];
                dhcp_rop_pkg::OPT_LEASE:  lease_next  = commit_val;
                dhcp_rop_pkg::OPT_MASK:   mask_next   = commit_val;
                dhcp_rop_pkg::OPT_ROUTER: router_next = commit_val;
                dhcp_rop_pkg::OPT_DNS:    dns_next    = commit_val;
                dhcp_rop_pkg::OPT_NTP:    ntp_next    = commit_val;
                dhcp_rop_pkg::OPT_SRV_ID: ident_next  = commit_val;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            is_reply_reg    <= 1'b0;
            code_reg        <= 8'd0;
            left_reg        <= 8'd0;
            idx_reg         <= 3'd0;
            shift_reg       <= 32'd0;
            mtype_reg       <= 8'd0;
            lease_reg       <= 32'd0;
            mask_reg        <= 32'd0;
            router_reg      <= 32'd0;
            dns_reg         <= 32'd0;
            ntp_reg         <= 32'd0;
            ident_reg       <= 32'd0;
            yaddr_reg       <= 32'd0;
            saddr_reg       <= 32'd0;
            offer_seen_reg  <= 1'b0;
            answer_seen_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            is_reply_reg    <= is_reply_next;
            code_reg        <= code_next;
            left_reg        <= left_next;
            idx_reg         <= idx_next;
            shift_reg       <= shift_next;
            mtype_reg       <= mtype_next;
            lease_reg       <= lease_next;
            mask_reg        <= mask_next;
            router_reg      <= router_next;
            dns_reg         <= dns_next;
            ntp_reg         <= ntp_next;
            ident_reg       <= ident_next;
            yaddr_reg       <= yaddr_next;
            saddr_reg       <= saddr_next;
            offer_seen_reg  <= offer_seen_next;
            answer_seen_reg <= answer_seen_next;
            res_valid_reg   <= res_valid_next;
            res_reg         <= res_next;
        end
    end

    // A request event is only issued once the offer flag is set.
    a_req_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.event_res == dhcp_rop_pkg::EV_REQUEST)
        |-> offer_seen_reg)
        else $error("request result without offer flag");

    // Assigned or refused events imply the answer flag.
    a_ans_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.event_res == dhcp_rop_pkg::EV_ASSIGNED ||
                           res_reg.event_res == dhcp_rop_pkg::EV_REFUSED))
        |-> answer_seen_reg)
        else $error("answer result without answer flag");

    // A clear transfer drops both session flags.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == dhcp_rop_pkg::KIND_CLEAR)
        |=> (!offer_seen_reg && !answer_seen_reg))
        else $error("session flags survived clear");

    // Option bytes of a non-reply never produce a result.
    a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == dhcp_rop_pkg::KIND_OPT && !is_reply_reg)
        |=> !res_valid_reg)
        else $error("result from non-reply message");

    // After a start transfer the parser waits for a code or idles.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.kind == dhcp_rop_pkg::KIND_START)
        |=> (phase_reg == PH_CODE || phase_reg == PH_IDLE))
        else $error("bad phase after start");

endmodule

// ===== test/dhcp_reply_option_parser_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the DHCP reply option parser.
// A queue of pending transfers (directed, random, then back-pressure) feeds a
// clocked driver; every accepted transfer runs through a behavioral parser
// that queues the expected reply results. A clocked monitor checks each
// accepted result against the oldest expected one, field by field.
module dhcp_reply_option_parser_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;  // no defined meaning, must be ignored

    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 10;    // settle time after the last result
    localparam int PHASE_ITEMS    = 80;
    localparam int PHASE_REPLIES  = 4;

    typedef enum logic [1:0] {ST_IDLE, ST_CODE, ST_LEN, ST_DATA} parse_state_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    dhcp_rop_pkg::in_item_t  item       = '0;
    logic                    res_valid;
    logic                    res_stall  = 1'b0;
    dhcp_rop_pkg::out_item_t res;

    dhcp_reply_option_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    dhcp_rop_pkg::in_item_t  outbound_items[$];
    dhcp_rop_pkg::out_item_t expected_replies[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int queued_count   = 0;
    int ends_queued    = 0;

    // Parser state as the block should hold it
    parse_state_t pst       = ST_IDLE;
    bit           p_reply   = 1'b0;
    logic [7:0]   p_code    = '0;
    logic [7:0]   p_left    = '0;
    logic [2:0]   p_idx     = '0;
    logic [31:0]  p_shift   = '0;
    logic [7:0]   p_type    = '0;
    logic [31:0]  p_lease   = '0;
    logic [31:0]  p_mask    = '0;
    logic [31:0]  p_router  = '0;
    logic [31:0]  p_dns     = '0;
    logic [31:0]  p_ntp     = '0;
    logic [31:0]  p_ident   = '0;
    logic [31:0]  p_your    = '0;
    logic [31:0]  p_srv     = '0;
    bit           offer_seen  = 1'b0;
    bit           answer_seen = 1'b0;

    // Option data complete: latch it into the slot its code selects.
    task automatic commit_option();
        case (p_code)
            dhcp_rop_pkg::OPT_MTYPE:  p_type   = p_shift[31:24];
            dhcp_rop_pkg::OPT_LEASE:  p_lease  = p_shift;
            dhcp_rop_pkg::OPT_MASK:   p_mask   = p_shift;
            dhcp_rop_pkg::OPT_ROUTER: p_router = p_shift;
            dhcp_rop_pkg::OPT_DNS:    p_dns    = p_shift;
            dhcp_rop_pkg::OPT_NTP:    p_ntp    = p_shift;
            dhcp_rop_pkg::OPT_SRV_ID: p_ident  = p_shift;
            default:    ;
        endcase
        pst = ST_CODE;
    endtask

    // Advance the expected parser by one accepted transfer.
    task automatic parse_item(input dhcp_rop_pkg::in_item_t t);
        dhcp_rop_pkg::out_item_t r;
        logic [1:0]              ev;
        case (t.kind)
            dhcp_rop_pkg::KIND_START:
            begin
                p_reply  = (t.opcode == dhcp_rop_pkg::OP_REPLY);
                p_your   = t.offered_ip;
                p_srv    = t.server_ip;
                p_code   = '0;
                p_left   = '0;
                p_idx    = '0;
                p_shift  = '0;
                p_type   = '0;
                p_lease  = '0;
                p_mask   = '0;
                p_router = '0;
                p_dns    = '0;
                p_ntp    = '0;
                p_ident  = '0;
                pst      = p_reply ? ST_CODE : ST_IDLE;
            end
            dhcp_rop_pkg::KIND_CLEAR:
            begin
                offer_seen  = 1'b0;
                answer_seen = 1'b0;
            end
            dhcp_rop_pkg::KIND_OPT:
            begin
                case (pst)
                    ST_CODE:
                    begin
                        if (t.opt_byte == dhcp_rop_pkg::OPT_END)
                        begin
                            pst = ST_IDLE;
                            if (p_reply)
                            begin
                                // first offer / first ack or nak of the session count
                                ev = dhcp_rop_pkg::EV_IGNORED;
                                if (p_type == dhcp_rop_pkg::MT_OFFER)
                                begin
                                    if (!offer_seen)
                                    begin
                                        offer_seen = 1'b1;
                                        ev = dhcp_rop_pkg::EV_REQUEST;
                                    end
                                end
                                else if (p_type == dhcp_rop_pkg::MT_ACK ||
                                         p_type == dhcp_rop_pkg::MT_NAK)
                                begin
                                    if (!answer_seen)
                                    begin
                                        answer_seen = 1'b1;
                                        ev = (p_type == dhcp_rop_pkg::MT_ACK)
                                           ? dhcp_rop_pkg::EV_ASSIGNED
                                           : dhcp_rop_pkg::EV_REFUSED;
                                    end
                                end
                                r = '{ev, p_your, p_srv, p_mask, p_router, p_dns, p_ntp,
                                      p_ident, p_lease};
                                expected_replies.push_back(r);
                            end
                        end
                        else if (t.opt_byte != dhcp_rop_pkg::OPT_PAD)
                        begin
                            p_code = t.opt_byte;
                            pst    = ST_LEN;
                        end
                    end
                    ST_LEN:
                    begin
                        p_left  = t.opt_byte;
                        p_idx   = '0;
                        p_shift = '0;
                        if (t.opt_byte == 8'd0)
                            commit_option();
                        else
                            pst = ST_DATA;
                    end
                    ST_DATA:
                    begin
                        // only the first four data bytes land, MSB first
                        if (p_idx < 3'd4)
                        begin
                            p_shift = p_shift | (32'(t.opt_byte) << (24 - 8 * p_idx));
                            p_idx   = p_idx + 3'd1;
                        end
                        p_left = p_left - 8'd1;
                        if (p_left == 8'd0)
                            commit_option();
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Stimulus builders; unused fields carry random values.
    function automatic dhcp_rop_pkg::in_item_t make_start(input logic [7:0] op,
                                                          input logic [31:0] yours,
                                                          input logic [31:0] srv);
        dhcp_rop_pkg::in_item_t t;
        t.kind       = dhcp_rop_pkg::KIND_START;
        t.opcode     = op;
        t.offered_ip = yours;
        t.server_ip  = srv;
        t.opt_byte   = 8'($urandom);
        return t;
    endfunction

    function automatic dhcp_rop_pkg::in_item_t make_noise(input logic [1:0] k);
        dhcp_rop_pkg::in_item_t t;
        t.kind       = k;
        t.opcode     = 8'($urandom);
        t.offered_ip = $urandom;
        t.server_ip  = $urandom;
        t.opt_byte   = 8'($urandom);
        return t;
    endfunction

    task automatic push(input dhcp_rop_pkg::in_item_t t);
        outbound_items.push_back(t);
        queued_count++;
    endtask

    task automatic push_opt(input logic [7:0] b);
        dhcp_rop_pkg::in_item_t t;
        t = make_noise(dhcp_rop_pkg::KIND_OPT);
        t.opt_byte = b;
        push(t);
    endtask

    // One message: optional noise, start transfer, a few options, usually an end.
    task automatic gen_message();
        int         n_opts;
        int         len;
        int         r;
        int         i;
        int         j;
        logic [7:0] code;
        logic [7:0] op;
        logic [7:0] mtype;
        r = $urandom_range(99);
        if (r < 30)
            push(make_noise(dhcp_rop_pkg::KIND_CLEAR));
        else if (r < 33)
            push(make_noise(KIND_UNUSED));
        else if (r < 38)
            push_opt(8'($urandom));
        op = ($urandom_range(99) < 85) ? dhcp_rop_pkg::OP_REPLY : 8'($urandom_range(255));
        push(make_start(op, $urandom, $urandom));
        n_opts = $urandom_range(3);
        for (i = 0; i < n_opts; i++)
        begin
            if ($urandom_range(99) < 15)
                push_opt(dhcp_rop_pkg::OPT_PAD);
            case ($urandom_range(9))
                0, 1, 2: code = dhcp_rop_pkg::OPT_MTYPE;
                3:       code = dhcp_rop_pkg::OPT_MASK;
                4:       code = dhcp_rop_pkg::OPT_ROUTER;
                5:       code = dhcp_rop_pkg::OPT_DNS;
                6:       code = dhcp_rop_pkg::OPT_NTP;
                7:       code = dhcp_rop_pkg::OPT_LEASE;
                8:       code = dhcp_rop_pkg::OPT_SRV_ID;
                default: code = 8'($urandom_range(1, 254));
            endcase
            r = $urandom_range(99);
            if (code == dhcp_rop_pkg::OPT_MTYPE && r < 85)
                len = 1;
            else if (r < 70)
                len = $urandom_range(1, 4);
            else if (r < 85)
                len = 0;
            else if (r < 99)
                len = $urandom_range(5, 12);
            else
                len = 255;
            r = $urandom_range(99);
            mtype = (r < 30) ? dhcp_rop_pkg::MT_OFFER :
                    (r < 60) ? dhcp_rop_pkg::MT_ACK :
                    (r < 85) ? dhcp_rop_pkg::MT_NAK : 8'($urandom);
            push_opt(code);
            push_opt(8'(len));
            for (j = 0; j < len; j++)
                push_opt((j == 0 && code == dhcp_rop_pkg::OPT_MTYPE) ? mtype
                                                                     : 8'($urandom));
        end
        // most messages close properly; the rest get cut off by the next start
        r = $urandom_range(99);
        if (r < 90)
        begin
            push_opt(dhcp_rop_pkg::OPT_END);
            if (op == dhcp_rop_pkg::OP_REPLY)
                ends_queued++;
            if (r < 8)
                push_opt(8'($urandom));
        end
    endtask

    task automatic wait_drain();
        while (outbound_items.size() != 0 || item_valid)
            @(negedge clk);
    endtask

    // Driver: hold the payload while stalled, otherwise offer the next transfer
    // or idle at the current rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                parse_item(item);
            if (!item_valid || !item_stall)
            begin
                if (outbound_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item       <= outbound_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result, then pick the next stall value.
    // A hold request turns into a long hold-off counted here.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        dhcp_rop_pkg::out_item_t want;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: expected none, actual %h",
                             $time, res);
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("event_res",     32'(want.event_res), 32'(res.event_res));
                    check_field("client_ip",     want.client_ip,      res.client_ip);
                    check_field("server_addr",   want.server_addr,    res.server_addr);
                    check_field("net_mask",      want.net_mask,       res.net_mask);
                    check_field("router_addr",   want.router_addr,    res.router_addr);
                    check_field("dns_addr",      want.dns_addr,       res.dns_addr);
                    check_field("ntp_addr",      want.ntp_addr,       res.ntp_addr);
                    check_field("server_ident",  want.server_ident,   res.server_ident);
                    check_field("lease_seconds", want.lease_seconds,  res.lease_seconds);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            res_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // Watchdog: too long without any transfer on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("[dhcp_reply_option_parser] ERROR");
                $finish;
            end
        end
    end

    // Sequencer: runs on the falling edge so queue and rate updates never race
    // the clocked driver and monitor.
    initial
    begin : sequencer
        int ph;
        int target;
        int ends_target;
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: stray byte before any start, unused kind with all ones,
        // pad, short zero-filled mask, zero-length lease, long router,
        // unknown option, bytes after end, a non-reply message.
        push_opt(dhcp_rop_pkg::OPT_MASK);
        push('{KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF});
        push(make_noise(dhcp_rop_pkg::KIND_CLEAR));
        push(make_start(dhcp_rop_pkg::OP_REPLY, 32'hFFFF_FFFF, 32'h0000_0000));
        push_opt(dhcp_rop_pkg::OPT_PAD);
        push_opt(dhcp_rop_pkg::OPT_MTYPE);
        push_opt(8'd1);
        push_opt(dhcp_rop_pkg::MT_OFFER);
        push_opt(dhcp_rop_pkg::OPT_MASK);
        push_opt(8'd2);
        push_opt(8'hFF);
        push_opt(8'hFF);
        push_opt(dhcp_rop_pkg::OPT_LEASE);
        push_opt(8'd0);
        push_opt(dhcp_rop_pkg::OPT_ROUTER);
        push_opt(8'd5);
        push_opt(8'h0A);
        push_opt(8'h0B);
        push_opt(8'hC0);
        push_opt(8'hA8);
        push_opt(8'h01);
        push_opt(8'd200);
        push_opt(8'd1);
        push_opt(8'h55);
        push_opt(dhcp_rop_pkg::OPT_END);
        push_opt(dhcp_rop_pkg::OPT_DNS);
        push(make_start(8'hFF, 32'h0000_0000, 32'hFFFF_FFFF));
        push_opt(dhcp_rop_pkg::OPT_END);
        wait_drain();

        // Random messages under each idling mix
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            target      = queued_count + PHASE_ITEMS;
            ends_target = ends_queued + PHASE_REPLIES;
            while (queued_count < target || ends_queued < ends_target)
                gen_message();
            wait_drain();
        end

        // Back-pressure: receiver holds off while short replies keep coming,
        // so results pile up and the input stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (k = 0; k < 15; k++)
        begin
            if (k % 5 == 0)
                push(make_noise(dhcp_rop_pkg::KIND_CLEAR));
            push(make_start(dhcp_rop_pkg::OP_REPLY, $urandom, $urandom));
            push_opt(dhcp_rop_pkg::OPT_MTYPE);
            push_opt(8'd1);
            push_opt((k % 3 == 0) ? dhcp_rop_pkg::MT_OFFER :
                     (k % 3 == 1) ? dhcp_rop_pkg::MT_ACK : dhcp_rop_pkg::MT_NAK);
            push_opt(dhcp_rop_pkg::OPT_END);
        end
        wait_drain();

        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0 && expected_replies.size() == 0)
            $display("[dhcp_reply_option_parser] OK");
        else
            $display("[dhcp_reply_option_parser] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dhcp_rop_pkg.sv
sv/dhcp_reply_option_parser.sv
test/dhcp_reply_option_parser_tb.sv
